// ===== src/lbp_pkg.sv =====
// Package: shared types and constants of the LSB-first bit packer.
`timescale 1ns / 1ps
`default_nettype none
package lbp_pkg;

	localparam int VALUE_W   = 64;
	localparam int COUNT_W   = 7;
	localparam int BYTE_W    = 8;
	localparam int PEND_W    = 7;
	localparam int HAVE_W    = 3;
	localparam int USED_W    = 4;
	localparam int LEFT_W    = 4;
	localparam int ACC_W     = VALUE_W + PEND_W;
	localparam logic [COUNT_W-1:0] MAX_COUNT = 7'd64;
	localparam logic [USED_W-1:0]  FULL_USED = 4'd8;

	typedef struct packed {
		logic [VALUE_W-1:0] value;
		logic [COUNT_W-1:0] bit_count;
		logic               flush;
	} req_t;

	typedef struct packed {
		logic [BYTE_W-1:0] out_byte;
		logic [USED_W-1:0] used_bits;
		logic              run_last;
	} rsp_t;

	// Normalized work item: count saturated, value masked to its count.
	typedef struct packed {
		logic [VALUE_W-1:0] value;
		logic [COUNT_W-1:0] bit_count;
		logic               flush;
	} work_t;

endpackage
`default_nettype wire

// ===== src/lsb_first_bit_packer_top.sv =====
// Top level: LSB-first variable-length bit packer with a one-byte result channel.
// Path: each request passes the queue, the byte buffer and the output register.
// Throughput: one result byte per cycle while rsp_stall is low, set by the single-byte
// result register; an item causes up to nine bytes, the next is taken with its last byte.
// Items causing no byte are still taken from the queue.
// Reset: arst_n clears pending bits, the queue and all valid flags at once.
`timescale 1ns / 1ps
`default_nettype none
module lsb_first_bit_packer_top
	import lbp_pkg::*;
#(
	parameter int QUEUE_DEPTH = 4
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic req_valid,
	output logic      req_stall,
	input  req_t      req,
	output logic      rsp_valid,
	input  wire logic rsp_stall,
	output rsp_t      rsp
);

	work_t work;
	work_t head;
	logic  q_full;
	logic  head_valid;
	logic  pop;

	// Hold off new requests only while the queue is full.
	assign req_stall = q_full;

	// Classify each request: saturate its count, drop unused value bits.
	lbp_front u_front (
		.req  (req),
		.work (work)
	);

	// Decouple the front end from the emitter so each side stalls on its own.
	lbp_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (req_valid && !q_full),
		.push_data  (work),
		.full       (q_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head       (head)
	);

	// Merge with pending bits, advance one byte a cycle unless the result is stalled, keep the remainder.
	lbp_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop),
		.rsp_valid  (rsp_valid),
		.rsp_stall  (rsp_stall),
		.rsp        (rsp)
	);

endmodule
`default_nettype wire

// ===== src/lbp_front.sv =====
// Front end: saturate the bit count and mask the value of each request.
`timescale 1ns / 1ps
`default_nettype none
module lbp_front
	import lbp_pkg::*;
(
	input  req_t  req,
	output work_t work
);

	logic [COUNT_W-1:0] count_sat;
	logic [VALUE_W-1:0] mask;

	always_comb begin
		count_sat = (req.bit_count > MAX_COUNT) ? MAX_COUNT : req.bit_count;
		// Build the low-bit mask; a full count keeps every bit.
		if (count_sat == MAX_COUNT) begin
			mask = '1;
		end else begin
			mask = ~({VALUE_W{1'b1}} << count_sat[HAVE_W+2:0]);
		end
		work.value     = req.value & mask;
		work.bit_count = count_sat;
		work.flush     = req.flush;
	end

endmodule
`default_nettype wire

// ===== src/lbp_queue.sv =====
// Work queue: small FIFO between the front end and the byte emitter.
`timescale 1ns / 1ps
`default_nettype none
module lbp_queue
	import lbp_pkg::*;
#(
	parameter int DEPTH = 4
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  push,
	input  work_t      push_data,
	output logic       full,
	input  wire logic  pop,
	output logic       head_valid,
	output work_t      head
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

	work_t             mem_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  cnt_q;

	assign full       = (cnt_q == FULL_CNT);
	assign head_valid = (cnt_q != '0);
	assign head       = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			unique case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule
`default_nettype wire

// ===== src/lbp_back.sv =====
// Back end: merge work with pending bits and emit one byte per cycle while rsp_stall is low.
`timescale 1ns / 1ps
`default_nettype none
module lbp_back
	import lbp_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  head_valid,
	input  work_t      head,
	output logic       pop,
	output logic       rsp_valid,
	input  wire logic  rsp_stall,
	output rsp_t       rsp
);

	logic [PEND_W-1:0] pend_q;
	logic [HAVE_W-1:0] have_q;
	logic              busy_q;
	logic [ACC_W-1:0]  buf_q;
	logic [LEFT_W-1:0] left_q;
	logic [USED_W-1:0] last_used_q;
	logic              out_valid_q;
	rsp_t              out_q;

	logic [COUNT_W-1:0] total;
	logic [LEFT_W-1:0]  full_bytes;
	logic [HAVE_W-1:0]  rem;
	logic               partial;
	logic [LEFT_W-1:0]  n_res;
	logic [ACC_W-1:0]   combined;
	logic [ACC_W-1:0]   shifted;
	logic               emit;
	logic               last_emit;

	always_comb begin
		total      = COUNT_W'(have_q) + head.bit_count;
		full_bytes = total[COUNT_W-1:HAVE_W];
		rem        = total[HAVE_W-1:0];
		partial    = head.flush && (rem != '0);
		n_res      = full_bytes + LEFT_W'(partial);
		combined   = (ACC_W'(head.value) << have_q) | ACC_W'(pend_q);
		shifted    = combined >> {full_bytes, 3'b000};
		emit       = busy_q && (!out_valid_q || !rsp_stall);
		last_emit  = emit && (left_q == LEFT_W'(1));
		pop        = head_valid && (!busy_q || last_emit);
	end

	assign rsp_valid = out_valid_q;
	assign rsp       = out_q;

	// Byte buffer and output payload.
	always_ff @(posedge clk) begin
		if (pop) begin
			buf_q       <= combined;
			last_used_q <= partial ? USED_W'(rem) : FULL_USED;
		end else if (emit) begin
			buf_q <= buf_q >> BYTE_W;
		end
		if (emit) begin
			out_q.out_byte  <= buf_q[BYTE_W-1:0];
			out_q.used_bits <= (left_q == LEFT_W'(1)) ? last_used_q : FULL_USED;
			out_q.run_last  <= (left_q == LEFT_W'(1));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q      <= '0;
			have_q      <= '0;
			busy_q      <= 1'b0;
			left_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				pend_q <= head.flush ? '0 : shifted[PEND_W-1:0];
				have_q <= head.flush ? '0 : rem;
				busy_q <= (n_res != '0);
				left_q <= n_res;
			end else if (emit) begin
				busy_q <= !last_emit;
				left_q <= left_q - 1'b1;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule
`default_nettype wire
